### src/bab_pkg.sv
package bab_pkg;

    localparam int BAB_MAX_WIDTH  = 512;
    localparam int BAB_MAX_HEIGHT = 512;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 9;
    localparam int SIZE_W  = 10;
    localparam int CIDX_W  = 1;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int RECIP_W = 17;
    localparam int RECIP_SHIFT = 16;

    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV,
        S_OUT
    } bab_state_t;

    // ceil(2^16 / d); exact floor division for sums below 2^12
    function automatic logic [RECIP_W-1:0] bab_recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

### src/bab_pix_if.sv
interface bab_pix_if
    import bab_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

### src/bab_res_if.sv
interface bab_res_if
    import bab_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] out_value;
    logic             last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last_of_run, output ready);
endinterface

### src/bab_cfg_if.sv
interface bab_cfg_if
    import bab_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [SIZE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/border_aware_box_blur_3x3_top.sv
// Flow: a pixel is taken in S_IDLE and the line memory answers in S_READ; each result
// then passes S_SUM (neighbor sum) and S_DIV (reciprocal multiply) before S_OUT shows it.
// A new pixel is taken only after all of its n = 0..4 results have been taken, as
// set by the single read-modify-write pass through the line memory and the shared divider.
// Reset: counters, window and frame size (512 x 512) are cleared at once; the line
// memory is not cleared and holds valid rows once they have been streamed in.
module border_aware_box_blur_3x3_top
    import bab_pkg::*;
#(
    parameter int MAX_WIDTH  = BAB_MAX_WIDTH,
    parameter int MAX_HEIGHT = BAB_MAX_HEIGHT
)
(
    input  logic      clk,
    input  logic      rst_n,
    bab_pix_if.sink   pix,
    bab_res_if.source res,
    bab_cfg_if.sink   cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    bab_state_t state_reg, state_next;

    logic [SIZE_W-1:0] fw_reg, fh_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     c_reg;
    logic [RW-1:0]     r_reg;
    logic [PIX_W-1:0]  px_reg;
    logic [PIX_W-1:0]  win_reg [9];
    logic [3:0]        pend_reg, pend_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  orow_reg, ocol_reg;
    logic              last_reg;
    logic [PIX_W-1:0]  value_reg;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_q_reg;

    logic [WW-1:0] wu;
    logic [HW-1:0] hu;
    logic          pix_acc, res_acc;
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic [RW:0]   r1;
    logic [CW:0]   c_inc;
    logic [RW:0]   r_inc;
    logic [3:0]    want;
    logic [3:0]    pick;
    logic [CW-1:0] k_col;
    logic [RW-1:0] k_row;
    logic [1:0]    k_wr, k_wc;
    logic [SUM_W-1:0] sum_c;
    logic [CNT_W-1:0] cnt_c;
    logic [SUM_W+RECIP_W-1:0] prod;

    // frame size in use
    always_comb
    begin
        if (fw_reg == '0)
            wu = WW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            wu = WW'(MAX_WIDTH);
        else
            wu = WW'(fw_reg);
        if (fh_reg == '0)
            hu = HW'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            hu = HW'(MAX_HEIGHT);
        else
            hu = HW'(fh_reg);
    end

    assign pix_acc = pix.valid && pix.ready;
    assign res_acc = res.valid && res.ready;
    assign cfg.ready = 1'b1;

    // position of the incoming pixel, then of the one after it
    always_comb
    begin
        c0 = col_reg;
        r1 = (RW+1)'(row_reg);
        if (col_reg >= wu)
        begin
            c0 = '0;
            r1 = (RW+1)'(row_reg) + 1'b1;
        end
        r0 = (r1 >= hu) ? '0 : r1[RW-1:0];
        c_inc = (CW+1)'(c0) + 1'b1;
        r_inc = (RW+1)'(r0) + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (pix_acc)
        begin
            if (c_inc >= wu)
            begin
                col_next = '0;
                row_next = (r_inc >= hu) ? '0 : r_inc[RW-1:0];
            end
            else
            begin
                col_next = c_inc[CW-1:0];
                row_next = r0;
            end
        end
    end

    always_comb
    begin
        want[0] = (r_reg != '0) && (c_reg != '0);
        want[1] = (r_reg != '0) && ((CW+1)'(c_reg) + 1'b1 == wu);
        want[2] = ((RW+1)'(r_reg) + 1'b1 == hu) && (c_reg != '0);
        want[3] = ((RW+1)'(r_reg) + 1'b1 == hu) && ((CW+1)'(c_reg) + 1'b1 == wu);
    end

    // lowest pending result goes next
    always_comb
    begin
        pick = pend_reg & (~pend_reg + 4'd1);
        k_row = r_reg;
        k_col = c_reg - 1'b1;
        k_wr = 2'd2;
        k_wc = 2'd1;
        case (pick)
            4'b0001:
            begin
                k_row = r_reg - 1'b1;
                k_col = c_reg - 1'b1;
                k_wr = 2'd1;
                k_wc = 2'd1;
            end
            4'b0010:
            begin
                k_row = r_reg - 1'b1;
                k_col = CW'(wu - 1'b1);
                k_wr = 2'd1;
                k_wc = 2'd2;
            end
            4'b0100:
            begin
                k_row = r_reg;
                k_col = c_reg - 1'b1;
                k_wr = 2'd2;
                k_wc = 2'd1;
            end
            4'b1000:
            begin
                k_row = r_reg;
                k_col = CW'(wu - 1'b1);
                k_wr = 2'd2;
                k_wc = 2'd2;
            end
            default:
            begin
                k_row = r_reg;
                k_col = c_reg;
            end
        endcase
    end

    // neighbor sum over in-frame taps of the window
    always_comb
    begin
        int xr, xc, ar, ac;
        sum_c = '0;
        cnt_c = '0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                xr = int'(k_wr) + dr - 1;
                xc = int'(k_wc) + dc - 1;
                ar = int'(k_row) + dr - 1;
                ac = int'(k_col) + dc - 1;
                if (xr <= 2 && xc <= 2 && ar >= 0 && ar < int'(hu)
                    && ac >= 0 && ac < int'(wu))
                begin
                    sum_c = sum_c + SUM_W'(win_reg[dr*3 + dc + (int'(k_wr) - 1)*3
                                                  + int'(k_wc) - 1]);
                    cnt_c = cnt_c + 1'b1;
                end
            end
        end
        if (cnt_c == '0)
            cnt_c = CNT_W'(1);
    end

    assign prod = SUM_W'(sum_reg) * bab_recip(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (pix_acc)
                    state_next = S_READ;
            S_READ:
                state_next = (want != '0) ? S_SUM : S_IDLE;
            S_SUM:
                state_next = S_DIV;
            S_DIV:
                state_next = S_OUT;
            S_OUT:
                if (res_acc)
                    state_next = (pend_reg != '0) ? S_SUM : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pix.ready = 1'b0;
        res.valid = 1'b0;
        pend_next = pend_reg;
        case (state_reg)
            S_IDLE:
                pix.ready = 1'b1;
            S_READ:
                pend_next = want;
            S_SUM:
                pend_next = pend_reg & ~pick;
            S_OUT:
                res.valid = 1'b1;
            default:
                pend_next = pend_reg;
        endcase
    end

    assign res.out_row     = orow_reg;
    assign res.out_col     = ocol_reg;
    assign res.out_value   = value_reg;
    assign res.last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fw_reg    <= SIZE_W'(512);
            fh_reg    <= SIZE_W'(512);
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg.data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg.data;
                    default:          fw_reg <= fw_reg;
                endcase
            end
            if (state_reg == S_READ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]     <= win_reg[i*3 + 1];
                    win_reg[i*3 + 1] <= win_reg[i*3 + 2];
                end
                win_reg[2] <= mem_q_reg[2*PIX_W-1:PIX_W];
                win_reg[5] <= mem_q_reg[PIX_W-1:0];
                win_reg[8] <= px_reg;
            end
        end
    end

    // line memory: {row r-2, row r-1} per column, read on accept, written back next cycle
    always_ff @(posedge clk)
    begin
        if (pix_acc)
            mem_q_reg <= line_mem[c0];
        if (state_reg == S_READ)
            line_mem[c_reg] <= {mem_q_reg[PIX_W-1:0], px_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            px_reg <= pix.pixel_in;
            c_reg  <= c0;
            r_reg  <= r0;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg  <= sum_c;
            cnt_reg  <= cnt_c;
            orow_reg <= POS_W'(k_row);
            ocol_reg <= POS_W'(k_col);
            last_reg <= ((pend_reg & ~pick) == '0);
        end
        if (state_reg == S_DIV)
            value_reg <= prod[RECIP_SHIFT +: PIX_W];
    end

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |-> !res.valid)
        else $error("pixel taken while a result is pending");

    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> state_reg == S_READ)
        else $error("memory read stage skipped");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_acc && res.last_of_run) |=> state_reg == S_IDLE)
        else $error("results continue after last of run");

    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_acc && !res.last_of_run) |=> state_reg == S_SUM)
        else $error("run ended without last marker");

endmodule

### tb/tb_border_aware_box_blur_3x3_top.sv
module tb_border_aware_box_blur_3x3_top
    import bab_pkg::*;
;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } blur_res_t;

    logic clk;
    logic rst_n;

    bab_pix_if pix ();
    bab_res_if res ();
    bab_cfg_if cfg ();

    border_aware_box_blur_3x3_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    // pixels waiting to be sent and filtered pixels still owed by the block
    logic [PIX_W-1:0] pixel_q[$];
    blur_res_t        blur_q[$];

    // shadow of the filter state
    logic [PIX_W-1:0]  row_m1[BAB_MAX_WIDTH];
    logic [PIX_W-1:0]  row_m2[BAB_MAX_WIDTH];
    logic [PIX_W-1:0]  win[9];
    int                col_pos;
    int                row_pos;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    int   errors = 0;
    int   send_gap;
    int   recv_gap;
    logic no_idle;
    logic hold_req;
    int   hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // mean of the in-frame neighbors of (r,c), centered at window cell (wr,wc)
    function automatic logic [PIX_W-1:0] box_mean(input int r, input int c, input int wr,
                                                  input int wc, input int w, input int h);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (wr + dr >= 0 && wr + dr <= 2 && wc + dc >= 0 && wc + dc <= 2 &&
                    r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w)
                begin
                    sum += win[(wr + dr) * 3 + wc + dc];
                    cnt++;
                end
            end
        end
        if (cnt == 0)
            cnt = 1;
        return PIX_W'(sum / cnt);
    endfunction

    task automatic filter_pixel(input logic [PIX_W-1:0] px);
        int        w;
        int        h;
        int        r;
        int        c;
        int        total;
        int        n;
        logic      want[4];
        int        pr[4];
        int        pc[4];
        int        wr[4];
        int        wc[4];
        blur_res_t e;
        w = clamp_dim(width_reg, BAB_MAX_WIDTH);
        h = clamp_dim(height_reg, BAB_MAX_HEIGHT);
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;
        for (int i = 0; i < 3; i++)
        begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = row_m2[c];
        win[5] = row_m1[c];
        win[8] = px;
        row_m2[c] = row_m1[c];
        row_m1[c] = px;

        want[0] = r >= 1 && c >= 1;
        want[1] = r >= 1 && c == w - 1;
        want[2] = r == h - 1 && c >= 1;
        want[3] = r == h - 1 && c == w - 1;
        pr = '{r - 1, r - 1, r, r};
        pc = '{c - 1, w - 1, c - 1, w - 1};
        wr = '{1, 1, 2, 2};
        wc = '{1, 2, 1, 2};
        total = 0;
        for (int i = 0; i < 4; i++)
            if (want[i])
                total++;
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (want[i])
            begin
                n++;
                e.row   = POS_W'(pr[i]);
                e.col   = POS_W'(pc[i]);
                e.value = box_mean(pr[i], pc[i], wr[i], wc[i], w, h);
                e.last  = (n == total);
                blur_q.push_back(e);
            end
        end

        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
            pix.pixel_in <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
                filter_pixel(pix.pixel_in);
            if (pix.valid && !pix.ready)
            begin
                // hold the offered pixel
            end
            else if (send_gap > 0)
            begin
                pix.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pixel_q.size() > 0)
            begin
                if (!no_idle && $urandom_range(0, 9) == 0)
                begin
                    pix.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 11);
                end
                else
                begin
                    pix.valid <= 1'b1;
                    pix.pixel_in <= pixel_q.pop_front();
                end
            end
            else
                pix.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_req && hold_cnt < 400)
            hold_cnt <= hold_cnt + 1;
    end

    // result monitor
    always @(posedge clk)
    begin
        blur_res_t e;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (blur_q.size() == 0)
                begin
                    $display("%0t: unexpected result row %0d col %0d value %0d last %0d",
                             $time, res.out_row, res.out_col, res.out_value,
                             res.last_of_run);
                    errors++;
                end
                else
                begin
                    e = blur_q.pop_front();
                    if (res.out_row !== e.row || res.out_col !== e.col ||
                        res.out_value !== e.value || res.last_of_run !== e.last)
                    begin
                        $display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 $time, e.row, e.col, e.value, e.last, res.out_row,
                                 res.out_col, res.out_value, res.last_of_run);
                        errors++;
                    end
                end
            end
            if (hold_req && hold_cnt < 400)
                res.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                res.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                res.ready <= 1'b0;
                recv_gap <= $urandom_range(0, 11);
            end
            else
                res.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    // wait until every pixel is taken and every result is back, then drain
    task automatic settle();
        do
            @(posedge clk);
        while (pixel_q.size() > 0 || pix.valid || blur_q.size() > 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(PIX_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int sent;
        int w;
        int h;
        rst_n = 1'b0;
        no_idle <= 1'b0;
        hold_req <= 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_FRAME_WIDTH;
        cfg.data = '0;
        width_reg = 512;
        height_reg = 512;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        for (int i = 0; i < BAB_MAX_WIDTH; i++)
        begin
            row_m1[i] = '0;
            row_m2[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // single pixel frame
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 1);
        pixel_q.push_back(8'hFF);
        settle();

        // oversized height clamps
        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 1023);
        send_frame(6);
        settle();

        // 3x3 frame with extreme pixel values; stall the output meanwhile
        write_reg(CFG_FRAME_WIDTH, 3);
        write_reg(CFG_FRAME_HEIGHT, 3);
        hold_req <= 1'b1;
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h01);
        settle();
        hold_req <= 1'b0;

        // zero width acts as one column
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 4);
        send_frame(4);
        settle();

        // shrink the frame while the counters sit past its new edges
        write_reg(CFG_FRAME_WIDTH, 6);
        write_reg(CFG_FRAME_HEIGHT, 8);
        send_frame(9);
        settle();
        write_reg(CFG_FRAME_WIDTH, 2);
        send_frame(4);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 2);
        send_frame(4);
        settle();

        sent = 0;
        while (sent < 90)
        begin
            if (sent > 60)
                no_idle <= 1'b1;
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if (sent + w * h > 100)
                h = (100 - sent) / w;
            if (h < 1)
                h = 1;
            write_reg(CFG_FRAME_WIDTH, SIZE_W'(w));
            write_reg(CFG_FRAME_HEIGHT, SIZE_W'(h));
            send_frame(w * h);
            sent += w * h;
            settle();
        end

        if (errors == 0 && blur_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
